>>> sv/tfi_pkg.sv
// Shared types and constants for the trade flow imbalance window.
`timescale 1ns / 1ps

package tfi_pkg;

    // Window counts fit the 11-bit length register.
    localparam int CNT_W = 11;

    // Q1.15 result and quotient width.
    localparam int Q_W = 16;

    // Quotient bits resolved per divider cycle.
    localparam int DIV_STEPS = 4;

    // Result item width on the master side, padded to whole bytes.
    localparam int OUT_W = 40;

    // Quote valid flags on the slave-side tuser.
    localparam int USER_IN_W = 2;

    // Saturated Q1.15 positive limit.
    localparam logic [Q_W-1:0] Q_POS_MAX = 16'h7FFF;

    // Request to the ratio divider.
    typedef struct packed {
        logic             start;
        logic             neg;
        logic [CNT_W-1:0] mag;
        logic [CNT_W-1:0] den;
    } t_div_req;

    // Response from the ratio divider.
    typedef struct packed {
        logic           valid;
        logic [Q_W-1:0] value;
    } t_div_rsp;

endpackage

>>> sv/tfi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tfi_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/tfi_div.sv
// Iterative ratio divider producing a saturated signed Q1.15 imbalance.
`timescale 1ns / 1ps

module tfi_div
    import tfi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int DIV_CYC   = Q_W / DIV_STEPS;
    localparam int DIV_CYC_W = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam logic [DIV_CYC_W-1:0] LAST_CYC = DIV_CYC_W'(DIV_CYC - 1);

    logic                 r_busy;
    logic                 r_valid;
    logic                 r_first;
    logic                 r_neg;
    logic [DIV_CYC_W-1:0] r_cyc;
    logic [CNT_W:0]       r_rem;
    logic [CNT_W-1:0]     r_den;
    logic [Q_W-1:0]       r_quo;

    logic [CNT_W:0]       n_rem;
    logic [Q_W-1:0]       n_quo;
    logic [CNT_W:0]       trial;
    logic                 qbit;

    // Restoring division steps. The first step compares the magnitude itself,
    // since the magnitude never exceeds the divisor; later steps shift first.
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        qbit  = 1'b0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (r_first && (k == 0)) begin
                trial = n_rem;
            end else begin
                trial = {n_rem[CNT_W-1:0], 1'b0};
            end
            if (trial >= {1'b0, r_den}) begin
                trial = trial - {1'b0, r_den};
                qbit  = 1'b1;
            end else begin
                qbit  = 1'b0;
            end
            n_rem = trial;
            n_quo = {n_quo[Q_W-2:0], qbit};
        end
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_first <= 1'b0;
            r_cyc   <= '0;
        end else if (i_req.start) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
            r_first <= 1'b1;
            r_cyc   <= '0;
        end else if (r_busy) begin
            r_first <= 1'b0;
            r_cyc   <= r_cyc + 1'b1;
            if (r_cyc == LAST_CYC) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.mag};
            r_den <= i_req.den;
            r_neg <= i_req.neg;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // A full-scale negative quotient maps exactly onto the most negative code.
    always_comb begin
        o_rsp.valid = r_valid;
        if (r_neg) begin
            o_rsp.value = Q_W'(~r_quo + 1'b1);
        end else if (r_quo[Q_W-1]) begin
            o_rsp.value = Q_POS_MAX;
        end else begin
            o_rsp.value = r_quo;
        end
    end

endmodule

>>> sv/trade_flow_imbalance_window.sv
// Top level of the sliding-window trade flow imbalance block.
//
//  Channel   | Direction | Payload (lowest bits first)
//  ----------+-----------+----------------------------------------------------
//  s_axis    | in        | tdata: print_px, reported_buy, bid_price, ask_price
//            |           | tuser: bid_valid, ask_valid
//  m_axis    | out       | tdata: imbalance, buy_total, sample_total, classified_buy
//  cfg       | in        | window_length, write enable with data
//
// One item is in flight at a time: the ring is read when it is accepted, then the
// count is updated and the ring written, then the divider resolves the quotient
// four bits per cycle, and last the output register is loaded; only then is the
// next item taken.
// Reset is synchronous and active low; it clears the window and sets the
// length to 1024. Writing the length also clears the window.
// A result that waits in the output register does not block the next item;
// that item's result waits in the divider until the output register is free,
// and no further item is taken meanwhile.
`timescale 1ns / 1ps

module trade_flow_imbalance_window
    import tfi_pkg::*;
#(
    parameter int MAX_WINDOW = 1024,
    parameter int PRICE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_wr_en,
    input  logic [CNT_W-1:0]     i_cfg_wr_data,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // print_px, reported_buy, bid_price, ask_price, zero padding
    input  logic [((3*PRICE_BITS+1+7)/8)*8-1:0] s_axis_tdata,
    // bid_valid, ask_valid
    input  logic [USER_IN_W-1:0] s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // imbalance, buy_total, sample_total, classified_buy, zero padding
    output logic [OUT_W-1:0]     m_axis_tdata
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam int P  = PRICE_BITS;
    localparam logic [AW-1:0]    LAST_PTR  = AW'(MAX_WINDOW - 1);
    localparam logic [SW-1:0]    DEPTH_SW  = SW'(MAX_WINDOW);
    localparam logic [31:0]      MAX_W32   = 32'(MAX_WINDOW);
    localparam logic [CNT_W-1:0] MAX_LEN   = CNT_W'(MAX_WINDOW);
    localparam logic [CNT_W-1:0] RESET_LEN = 11'd1024;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_DIV
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cfg_len;
    logic [AW-1:0]    r_oldest;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_buys;
    logic             r_cls;
    logic             r_full;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    logic [CNT_W-1:0] eff_len;
    logic             in_accept;
    logic [P-1:0]     print_px;
    logic             reported_buy;
    logic [P-1:0]     bid_price;
    logic [P-1:0]     ask_price;
    logic [P:0]       quote_sum;
    logic             is_buy;

    logic             ring_rd_data;
    logic [AW-1:0]    n_oldest;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] n_buys;
    logic [CNT_W-1:0] kept;
    logic [SW-1:0]    slot_sum;
    logic [AW-1:0]    slot;
    logic [CNT_W:0]   twice_buys;
    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic             out_free;
    logic             out_load;

    // Effective window length: zero acts as one, and the ring depth caps it.
    always_comb begin
        if (r_cfg_len == '0) begin
            eff_len = CNT_W'(1);
        end else if ({21'b0, r_cfg_len} > MAX_W32) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = r_cfg_len;
        end
    end

    // Unpack the trade; classify by mid quote if quotes valid, else by reported_buy.
    assign print_px     = s_axis_tdata[P-1:0];
    assign reported_buy = s_axis_tdata[P];
    assign bid_price    = s_axis_tdata[2*P:P+1];
    assign ask_price    = s_axis_tdata[3*P:2*P+1];
    assign quote_sum    = {1'b0, bid_price} + {1'b0, ask_price};

    always_comb begin
        if (s_axis_tuser[0] && s_axis_tuser[1]) begin
            is_buy = {print_px, 1'b0} >= quote_sum;
        end else begin
            is_buy = reported_buy;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Window update: evict the oldest side when full, then append the new one.
    always_comb begin
        n_buys   = r_buys - CNT_W'(r_full && ring_rd_data) + CNT_W'(r_cls);
        kept     = r_full ? (r_count - 1'b1) : r_count;
        n_count  = kept + 1'b1;
        if (r_full) begin
            n_oldest = (r_oldest == LAST_PTR) ? '0 : (r_oldest + 1'b1);
        end else begin
            n_oldest = r_oldest;
        end
        slot_sum = SW'(n_oldest) + SW'(kept);
        if (slot_sum >= DEPTH_SW) begin
            slot = AW'(slot_sum - DEPTH_SW);
        end else begin
            slot = AW'(slot_sum);
        end
    end

    tfi_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_UPD),
        .i_wr_addr (slot),
        .i_wr_data (r_cls),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_oldest),
        .o_rd_data (ring_rd_data)
    );

    // Divider request: magnitude and sign of twice the buys minus the samples.
    assign twice_buys = {n_buys, 1'b0};

    always_comb begin
        div_req.start = (r_state == S_UPD);
        div_req.den   = n_count;
        if (twice_buys >= {1'b0, n_count}) begin
            div_req.neg = 1'b0;
            div_req.mag = CNT_W'(twice_buys - {1'b0, n_count});
        end else begin
            div_req.neg = 1'b1;
            div_req.mag = CNT_W'({1'b0, n_count} - twice_buys);
        end
    end

    tfi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free = !r_out_valid || m_axis_tready;
    assign out_load = (r_state == S_DIV) && div_rsp.valid && out_free;

    // Window state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= RESET_LEN;
            r_oldest  <= '0;
            r_count   <= '0;
            r_buys    <= '0;
        end else if (i_cfg_wr_en) begin
            r_cfg_len <= i_cfg_wr_data;
            r_oldest  <= '0;
            r_count   <= '0;
            r_buys    <= '0;
        end else if (r_state == S_UPD) begin
            r_oldest  <= n_oldest;
            r_count   <= n_count;
            r_buys    <= n_buys;
        end
    end

    // Sequencer with the registered output item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_cls   <= is_buy;
                        r_full  <= (r_count >= eff_len);
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (out_load) begin
                        r_out_data  <= {1'b0, r_cls, r_count, r_buys, div_rsp.value};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // The output item is filled from the divider or drained by the receiver.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> sv/tfi_checker.sv
// Port-level assertions for the trade flow imbalance window, bound to the top level.
`timescale 1ns / 1ps

module tfi_checker
    import tfi_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic [Q_W-1:0]   imb;
    logic [CNT_W-1:0] buys;
    logic [CNT_W-1:0] samples;

    assign imb     = m_axis_tdata[15:0];
    assign buys    = m_axis_tdata[26:16];
    assign samples = m_axis_tdata[37:27];

    // A stalled result item holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // One trade at a time: ready drops right after an accepted item.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while the previous one is in flight");

    // Counts are consistent: the window is never empty and buys fit in it.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (samples != '0) && (buys <= samples))
        else $error("inconsistent window counts");

    // The imbalance sign follows the buy majority.
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (imb[Q_W-1] == ({buys, 1'b0} < {1'b0, samples})))
        else $error("imbalance sign disagrees with counts");

    // An all-sell window gives exactly minus one.
    a_all_sell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (buys == '0) |-> (imb == 16'h8000))
        else $error("all-sell window is not minus one");

endmodule

bind trade_flow_imbalance_window tfi_checker u_tfi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
